/* rtl/rda_pkg.sv */
// Package with the recurrence codes and calendar helper functions for the date advance core.
`default_nettype none

package rda_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CodeW  = 3;

  // Multiplicative inverse of 25 modulo 2**YearW, and the largest product that
  // marks a multiple of 25 (floor((2**YearW - 1) / 25)).
  localparam logic [YearW-1:0] Inv25   = YearW'(7209);
  localparam logic [YearW-1:0] Lim25   = YearW'(((1 << YearW) - 1) / 25);

  typedef enum logic [CodeW-1:0] {
    PER_WEEKLY      = 3'd0,
    PER_FORTNIGHTLY = 3'd1,
    PER_MONTHLY     = 3'd2,
    PER_QUARTERLY   = 3'd3,
    PER_YEARLY      = 3'd4
  } period_e;

  typedef enum logic [MonthW-1:0] {
    MON_JAN = 4'd1,
    MON_FEB = 4'd2,
    MON_APR = 4'd4,
    MON_JUN = 4'd6,
    MON_SEP = 4'd9,
    MON_NOV = 4'd11,
    MON_DEC = 4'd12
  } month_e;

  // Gregorian leap rule. A multiple of 100 is a multiple of 4 and of 25, and a
  // multiple of 400 is a multiple of 16 and of 25. Divisibility by 25 uses the
  // odd-divisor inverse test, a single constant multiply.
  function automatic logic is_leap(input logic [YearW-1:0] year);
    logic [YearW-1:0] prod;
    logic             div25;
    prod  = YearW'(year * Inv25);
    div25 = (prod <= Lim25);
    return ((year[1:0] == 2'd0) && !div25) || ((year[3:0] == 4'd0) && div25);
  endfunction

  // Length of a month, 1 to 12; other codes give zero.
  function automatic logic [DayW-1:0] days_in(input logic [MonthW-1:0] month,
                                              input logic leap);
    logic [DayW-1:0] len;
    unique case (month)
      MON_FEB:                          len = leap ? DayW'(29) : DayW'(28);
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = DayW'(30);
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DayW'(31);
      default:                          len = '0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

/* rtl/rda_step.sv */
// Combinational next-occurrence computation for one registered date request.
`default_nettype none

module rda_step import rda_pkg::*; (
  input  wire logic [DayW-1:0]   day_i,
  input  wire logic [MonthW-1:0] month_i,
  input  wire logic [YearW-1:0]  year_i,
  input  wire logic [CodeW-1:0]  code_i,
  output logic      [DayW-1:0]   day_o,
  output logic      [MonthW-1:0] month_o,
  output logic      [YearW-1:0]  year_o
);

  logic [YearW-1:0]  year_inc;
  logic              leap_cur;
  logic              leap_inc;
  logic              date_ok;
  logic [DayW:0]     day_sum;
  logic [DayW-1:0]   dim;
  logic [MonthW:0]   month_sum;
  logic [MonthW-1:0] month_new;
  logic              wrap;

  // Both leap flags are formed in parallel so no step waits on the increment.
  assign year_inc = year_i + YearW'(1);
  assign leap_cur = is_leap(year_i);
  assign leap_inc = is_leap(year_inc);
  assign date_ok  = (day_i != '0) && (month_i >= MonthW'(1)) && (month_i <= MON_DEC);

  always_comb begin
    day_o     = day_i;
    month_o   = month_i;
    year_o    = year_i;
    day_sum   = '0;
    dim       = '0;
    month_sum = '0;
    month_new = '0;
    wrap      = 1'b0;
    if (date_ok) begin
      case (code_i)
        PER_WEEKLY, PER_FORTNIGHTLY: begin
          day_sum = {1'b0, day_i} + ((code_i == PER_WEEKLY) ? (DayW+1)'(7) : (DayW+1)'(14));
          dim     = days_in(month_i, leap_cur);
          day_o   = day_sum[DayW-1:0];
          if (day_sum > {1'b0, dim}) begin
            day_o = DayW'(day_sum - {1'b0, dim});
            if (month_i == MON_DEC) begin
              month_o = MON_JAN;
              year_o  = year_inc;
            end else begin
              month_o = month_i + MonthW'(1);
            end
          end
        end
        PER_MONTHLY, PER_QUARTERLY: begin
          month_sum = {1'b0, month_i} +
                      ((code_i == PER_MONTHLY) ? (MonthW+1)'(1) : (MonthW+1)'(3));
          wrap      = (month_sum > (MonthW+1)'(12));
          month_new = wrap ? MonthW'(month_sum - (MonthW+1)'(12)) : month_sum[MonthW-1:0];
          dim       = days_in(month_new, wrap ? leap_inc : leap_cur);
          month_o   = month_new;
          year_o    = wrap ? year_inc : year_i;
          day_o     = (day_i > dim) ? dim : day_i;
        end
        PER_YEARLY: begin
          dim    = days_in(month_i, leap_inc);
          year_o = year_inc;
          day_o  = (day_i > dim) ? dim : day_i;
        end
        default: begin
          day_o = day_i;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/recurring_date_advance_core.sv */
// Top level of the recurring date advance core: request register, date step, result register.
// An accepted request passes from the request register through the date step into the result register.
// Throughput: one request per cycle while out_stall_i is low; a stalled result holds the flow.
// A waiting result does not block intake while the request register is free to move.
// Reset: rst_ni clears both valid flags asynchronously; payload registers are not reset.
`default_nettype none

module recurring_date_advance_core import rda_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [DayW-1:0]   start_day_i,
  input  wire logic [MonthW-1:0] start_month_i,
  input  wire logic [YearW-1:0]  start_year_i,
  input  wire logic [CodeW-1:0]  period_code_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [DayW-1:0]   next_day_o,
  output logic      [MonthW-1:0] next_month_o,
  output logic      [YearW-1:0]  next_year_o
);

  // Request register stage.
  logic              req_valid_q;
  logic [DayW-1:0]   req_day_q;
  logic [MonthW-1:0] req_month_q;
  logic [YearW-1:0]  req_year_q;
  logic [CodeW-1:0]  req_code_q;

  // Result register stage.
  logic              res_valid_q;
  logic [DayW-1:0]   res_day_q;
  logic [MonthW-1:0] res_month_q;
  logic [YearW-1:0]  res_year_q;

  logic [DayW-1:0]   step_day;
  logic [MonthW-1:0] step_month;
  logic [YearW-1:0]  step_year;

  logic res_load;
  logic req_load;

  // The result register takes a new value when it is empty or its result is
  // being taken this cycle. The request register can move whenever the
  // result register can, so a full request register stalls only behind a
  // result that is itself stalled.
  assign res_load   = !res_valid_q || !out_stall_i;
  assign in_stall_o = req_valid_q && !res_load;
  assign req_load   = !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_load) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_load && in_valid_i) begin
      req_day_q   <= start_day_i;
      req_month_q <= start_month_i;
      req_year_q  <= start_year_i;
      req_code_q  <= period_code_i;
    end
  end

  // The whole date step for one request sits between the two registers.
  rda_step u_step (
    .day_i   (req_day_q),
    .month_i (req_month_q),
    .year_i  (req_year_q),
    .code_i  (req_code_q),
    .day_o   (step_day),
    .month_o (step_month),
    .year_o  (step_year)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load && req_valid_q) begin
      res_day_q   <= step_day;
      res_month_q <= step_month;
      res_year_q  <= step_year;
    end
  end

  assign out_valid_o  = res_valid_q;
  assign next_day_o   = res_day_q;
  assign next_month_o = res_month_q;
  assign next_year_o  = res_year_q;

  // An accepted request is held in the request register on the next cycle.
  a_req_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> req_valid_q)
    else $error("accepted request not captured");

  // Intake stalls only behind a full result register whose result is stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (req_valid_q && res_valid_q && out_stall_i))
    else $error("intake stalled without a blocked result");

  // A taken result with nothing behind it leaves the output empty.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !req_valid_q) |=> !out_valid_o)
    else $error("result repeated after it was taken");

  // A pending request moves into an empty result register on the next cycle.
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && !res_valid_q) |=> out_valid_o)
    else $error("pending request did not reach the result register");

endmodule

`default_nettype wire
